// ===== sv/blpg_pkg.sv =====
package blpg_pkg;

  localparam int unsigned CoordWidth = 12;
  localparam int unsigned DecWidth   = CoordWidth + 3;

  typedef logic [CoordWidth-1:0]      coord_t;
  typedef logic signed [DecWidth-1:0] dec_t;
  typedef logic signed [1:0]          sign_t;

  typedef enum logic [0:0] {
    OpStart = 1'b0,
    OpStep  = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e opcode;
    coord_t  start_x;
    coord_t  start_y;
    coord_t  end_x;
    coord_t  end_y;
  } cmd_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } pixel_t;

  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    coord_t target_x;
    coord_t target_y;
    coord_t abs_dx;
    coord_t abs_dy;
    sign_t  step_sign_x;
    sign_t  step_sign_y;
    logic   x_major;
    dec_t   decision;
    logic   active;
  } line_state_t;

endpackage

// ===== sv/bresenham_line_pixel_generator_core.sv =====
// a result is held in the input register and then in the output register before it leaves
// throughput: one item per cycle unless the output stalls, as the line state is updated for each accepted item
// a step item with no line active is consumed and gives no result
// reset: asynchronous, clears the line state, no line active, both stages empty
module bresenham_line_pixel_generator_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  blpg_pkg::cmd_t   in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output blpg_pkg::pixel_t out_item_o
);

  logic                  in_valid_q;
  blpg_pkg::cmd_t        in_item_q;
  logic                  out_valid_q;
  blpg_pkg::pixel_t      out_item_q;
  blpg_pkg::pixel_t      out_item_d;
  blpg_pkg::line_state_t line_q;
  blpg_pkg::line_state_t line_d;
  blpg_pkg::line_state_t setup_state;
  blpg_pkg::line_state_t step_state;
  logic                  setup_last;
  logic                  step_last;
  logic                  out_free;
  logic                  fire;
  logic                  is_start;
  logic                  has_result;

  blpg_setup u_setup (
    .cmd_i   (in_item_q),
    .state_o (setup_state),
    .last_o  (setup_last)
  );

  blpg_step u_step (
    .state_i (line_q),
    .state_o (step_state),
    .last_o  (step_last)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign is_start   = (in_item_q.opcode == blpg_pkg::OpStart);
  assign has_result = is_start || line_q.active;

  always_comb begin
    if (is_start) begin
      line_d                = setup_state;
      out_item_d.pixel_x    = setup_state.cur_x;
      out_item_d.pixel_y    = setup_state.cur_y;
      out_item_d.last_pixel = setup_last;
    end else if (line_q.active) begin
      line_d                = step_state;
      out_item_d.pixel_x    = step_state.cur_x;
      out_item_d.pixel_y    = step_state.cur_y;
      out_item_d.last_pixel = step_last;
    end else begin
      line_d                = line_q;
      out_item_d.pixel_x    = line_q.cur_x;
      out_item_d.pixel_y    = line_q.cur_y;
      out_item_d.last_pixel = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      line_q      <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= fire && has_result;
      end
      if (fire) begin
        line_q <= line_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
    if (fire && has_result) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_start_gives_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && is_start) |=> out_valid_o)
    else $error("start item gave no pixel");

  a_idle_step_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !is_start && !line_q.active) |=> (!out_valid_o && $stable(line_q)))
    else $error("step with no line changed state or gave a pixel");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && has_result && out_item_d.last_pixel) |=> !line_q.active)
    else $error("line still active after its last pixel");

  a_active_not_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q.active |-> (line_q.x_major ? (line_q.cur_x != line_q.target_x)
                                      : (line_q.cur_y != line_q.target_y)))
    else $error("active line already at its end point");

endmodule

// ===== sv/blpg_setup.sv =====
module blpg_setup (
  input  blpg_pkg::cmd_t        cmd_i,
  output blpg_pkg::line_state_t state_o,
  output logic                  last_o
);

  logic signed [blpg_pkg::CoordWidth:0] dx;
  logic signed [blpg_pkg::CoordWidth:0] dy;
  logic signed [blpg_pkg::CoordWidth:0] dx_abs;
  logic signed [blpg_pkg::CoordWidth:0] dy_abs;
  blpg_pkg::coord_t                     adx;
  blpg_pkg::coord_t                     ady;
  logic                                 x_major;
  logic                                 last;

  assign dx = $signed({1'b0, cmd_i.end_x}) - $signed({1'b0, cmd_i.start_x});
  assign dy = $signed({1'b0, cmd_i.end_y}) - $signed({1'b0, cmd_i.start_y});

  assign dx_abs = dx[blpg_pkg::CoordWidth] ? -dx : dx;
  assign dy_abs = dy[blpg_pkg::CoordWidth] ? -dy : dy;
  assign adx    = dx_abs[blpg_pkg::CoordWidth-1:0];
  assign ady    = dy_abs[blpg_pkg::CoordWidth-1:0];

  // ties go to y
  assign x_major = ady < adx;
  assign last    = x_major ? (cmd_i.start_x == cmd_i.end_x) : (cmd_i.start_y == cmd_i.end_y);

  always_comb begin
    state_o.cur_x       = cmd_i.start_x;
    state_o.cur_y       = cmd_i.start_y;
    state_o.target_x    = cmd_i.end_x;
    state_o.target_y    = cmd_i.end_y;
    state_o.abs_dx      = adx;
    state_o.abs_dy      = ady;
    state_o.step_sign_x = (dx == '0) ? 2'sb00 : (dx[blpg_pkg::CoordWidth] ? 2'sb11 : 2'sb01);
    state_o.step_sign_y = (dy == '0) ? 2'sb00 : (dy[blpg_pkg::CoordWidth] ? 2'sb11 : 2'sb01);
    state_o.x_major     = x_major;
    if (x_major) begin
      state_o.decision = $signed({2'b00, ady, 1'b0}) - $signed({3'b000, adx});
    end else begin
      state_o.decision = $signed({2'b00, adx, 1'b0}) - $signed({3'b000, ady});
    end
    state_o.active = !last;
  end

  assign last_o = last;

endmodule

// ===== sv/blpg_step.sv =====
module blpg_step (
  input  blpg_pkg::line_state_t state_i,
  output blpg_pkg::line_state_t state_o,
  output logic                  last_o
);

  logic             dec_ge;
  blpg_pkg::coord_t inc_x;
  blpg_pkg::coord_t inc_y;
  blpg_pkg::coord_t nx;
  blpg_pkg::coord_t ny;
  blpg_pkg::dec_t   two_major;
  blpg_pkg::dec_t   two_minor;
  logic             last;

  assign dec_ge = !state_i.decision[blpg_pkg::DecWidth-1];

  assign inc_x = {{(blpg_pkg::CoordWidth-2){state_i.step_sign_x[1]}}, state_i.step_sign_x};
  assign inc_y = {{(blpg_pkg::CoordWidth-2){state_i.step_sign_y[1]}}, state_i.step_sign_y};

  always_comb begin
    if (state_i.x_major) begin
      nx        = state_i.cur_x + inc_x;
      ny        = dec_ge ? state_i.cur_y + inc_y : state_i.cur_y;
      two_major = $signed({2'b00, state_i.abs_dx, 1'b0});
      two_minor = $signed({2'b00, state_i.abs_dy, 1'b0});
      last      = (nx == state_i.target_x);
    end else begin
      nx        = dec_ge ? state_i.cur_x + inc_x : state_i.cur_x;
      ny        = state_i.cur_y + inc_y;
      two_major = $signed({2'b00, state_i.abs_dy, 1'b0});
      two_minor = $signed({2'b00, state_i.abs_dx, 1'b0});
      last      = (ny == state_i.target_y);
    end
  end

  always_comb begin
    state_o          = state_i;
    state_o.cur_x    = nx;
    state_o.cur_y    = ny;
    state_o.decision = state_i.decision + two_minor - (dec_ge ? two_major : '0);
    state_o.active   = !last;
  end

  assign last_o = last;

endmodule
